FILE: sv/scpq_pkg.sv
// ----------------------------------------------------------------------------
// scpq_pkg: shared types and constants for the serial command parser queue
// Command codes, character codes, queue sizing and the result item layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scpq_pkg;

  // Queue sizing
  localparam int QUEUE_DEPTH = 10;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int QCNT_W      = 4;

  // Item commands
  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_PULL = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // Character codes
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_F    = 8'h46;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_LT   = 8'h74;
  localparam logic [7:0] CH_S    = 8'h73;

  // One result item
  typedef struct packed {
    logic              pushed;
    logic              dropped;
    logic              pull_valid;
    logic [31:0]       pulled_word;
    logic [QCNT_W-1:0] queue_count;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c == CH_F) || (c == CH_B) || (c == CH_T) || (c == CH_LT) || (c == CH_S);
  endfunction

endpackage

`default_nettype wire

FILE: sv/scpq_if.sv
// ----------------------------------------------------------------------------
// scpq channel interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface scpq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  rx_byte;
  logic [31:0] push_word;

  modport source (output valid, output command, output rx_byte, output push_word,
                  input ready);
  modport sink   (input valid, input command, input rx_byte, input push_word,
                  output ready);
endinterface

interface scpq_out_if;
  logic        valid;
  logic        ready;
  logic        pushed;
  logic        dropped;
  logic        pull_valid;
  logic [31:0] pulled_word;
  logic [3:0]  queue_count;

  modport source (output valid, output pushed, output dropped, output pull_valid,
                  output pulled_word, output queue_count, input ready);
  modport sink   (input valid, input pushed, input dropped, input pull_valid,
                  input pulled_word, input queue_count, output ready);
endinterface

`default_nettype wire

FILE: sv/serial_command_parser_with_queue_unit.sv
// ----------------------------------------------------------------------------
// serial_command_parser_with_queue_unit
// Serial frame parser feeding a ring queue of 4-byte command messages.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one item per handshake: command (0 serial byte, 1 direct
//         push of push_word, 2 pull oldest message, 3 no operation), rx_byte
//         and push_word. A frame is newline, letter (F B T t s), two digits,
//         then '!' (or a third digit for 's'); it pushes letter in bits 7:0.
//   out_o returns exactly one result item per input item, in order:
//         pushed, dropped, pull_valid, pulled_word, queue_count.
//   The result of an accepted item is registered in the result register,
//   or in the skid register while an earlier result waits. Throughput is
//   one item per cycle while in_i.ready is high; parser state, queue
//   pointers and count update on accept, and a head register holds the
//   store entry at the read pointer, refilled from the next read pointer.
//   A two-entry output stage (result register plus skid register) lets an
//   item be accepted while an earlier result still waits; in_i.ready drops
//   only when both entries are full, i.e. once two results wait untaken.
//   Reset (rst_ni low) empties the queue, clears the pointers and returns
//   the parser to waiting for a newline; the message store itself is not
//   cleared and only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_command_parser_with_queue_unit
  import scpq_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  scpq_in_if.sink      in_i,
  scpq_out_if.source   out_o
);

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LETTER = 3'd1,
    PH_DIG1   = 3'd2,
    PH_DIG2   = 3'd3,
    PH_TERM   = 3'd4
  } phase_e;

  phase_e            ph_q, ph_d;
  logic [7:0]        letter_q, letter_d;
  logic [15:0]       digits_q, digits_d;
  logic [SLOT_W-1:0] wr_q, wr_d;
  logic [SLOT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  logic [31:0] mem [QUEUE_DEPTH];
  logic [31:0] head_q;

  // Output stage: result register and skid register
  res_t res_q, skid_q, res_new;
  logic res_v_q, skid_v_q;

  logic        accept, take;
  logic        frame_done;
  logic [31:0] frame_word;
  logic        push_req, do_push, do_pull, full, empty;
  logic [31:0] push_data;
  logic [7:0]  c;

  assign accept     = in_i.valid && in_i.ready;
  assign take       = res_v_q && out_o.ready;
  assign in_i.ready = !skid_v_q;
  assign c          = in_i.rx_byte;

  assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_q == '0);

  // Frame parser: next phase and captured fields for a serial byte
  always_comb begin
    ph_d       = ph_q;
    letter_d   = letter_q;
    digits_d   = digits_q;
    frame_done = 1'b0;
    frame_word = {c, digits_q, letter_q};
    if (in_i.command == CMD_BYTE) begin
      unique case (ph_q)
        PH_LETTER: begin
          if (is_letter(c)) begin
            letter_d = c;
            ph_d     = PH_DIG1;
          end else begin
            ph_d = PH_IDLE;
          end
        end
        PH_DIG1: begin
          if (is_digit(c)) begin
            digits_d[7:0] = c;
            ph_d          = PH_DIG2;
          end else begin
            ph_d = PH_IDLE;
          end
        end
        PH_DIG2: begin
          if (is_digit(c)) begin
            digits_d[15:8] = c;
            ph_d           = PH_TERM;
          end else begin
            ph_d = PH_IDLE;
          end
        end
        PH_TERM: begin
          // 's' ends in a digit, every other letter in '!'
          frame_done = (letter_q == CH_S) ? is_digit(c) : (c == CH_BANG);
          ph_d       = PH_IDLE;
        end
        default: begin
          // waiting for newline; out-of-range phases behave the same
          ph_d = (c == CH_NL) ? PH_LETTER : PH_IDLE;
        end
      endcase
    end
  end

  // Queue control and the result of this item
  always_comb begin
    push_req  = ((in_i.command == CMD_BYTE) && frame_done) || (in_i.command == CMD_PUSH);
    push_data = (in_i.command == CMD_PUSH) ? in_i.push_word : frame_word;
    do_push   = push_req && !full;
    do_pull   = (in_i.command == CMD_PULL) && !empty;

    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d  = (wr_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      cnt_d = cnt_q + 1'b1;
    end
    if (do_pull) begin
      rd_d  = (rd_q == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_d = cnt_q - 1'b1;
    end

    res_new.pushed      = do_push;
    res_new.dropped     = push_req && full;
    res_new.pull_valid  = do_pull;
    res_new.pulled_word = do_pull ? head_q : 32'd0;
    res_new.queue_count = QCNT_W'(cnt_d);
  end

  // Message store: written on push, no reset. Refill the head register from
  // the next read pointer; a push into an empty queue lands there directly.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (do_push) begin
        mem[wr_q] <= push_data;
      end
      if (do_push && (wr_q == rd_d)) begin
        head_q <= push_data;
      end else begin
        head_q <= mem[rd_d];
      end
    end
  end

  // Parser and queue state: advance only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_IDLE;
      letter_q <= '0;
      digits_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else if (accept) begin
      ph_q     <= ph_d;
      letter_q <= letter_d;
      digits_q <= digits_d;
      wr_q     <= wr_d;
      rd_q     <= rd_d;
      cnt_q    <= cnt_d;
    end
  end

  // Output stage: refill the result register from skid first, then from
  // the new item; park the new item in skid when the result is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (take) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          res_v_q <= accept;
        end
      end else if (accept) begin
        if (res_v_q) begin
          skid_v_q <= 1'b1;
        end else begin
          res_v_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && skid_v_q) begin
      res_q <= skid_q;
    end else if (accept && (take || !res_v_q)) begin
      res_q <= res_new;
    end
    if (accept && res_v_q && !take) begin
      skid_q <= res_new;
    end
  end

  assign out_o.valid       = res_v_q;
  assign out_o.pushed      = res_q.pushed;
  assign out_o.dropped     = res_q.dropped;
  assign out_o.pull_valid  = res_q.pull_valid;
  assign out_o.pulled_word = res_q.pulled_word;
  assign out_o.queue_count = res_q.queue_count;

  // Checks
  a_skid_behind_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> res_v_q)
    else $error("skid entry held without a result entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");

  a_pull_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.command == CMD_PULL) && (cnt_q != '0))
      |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("pull from non-empty queue did not lower count");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: serial command parser with message queue
// Drives serial bytes, direct pushes, pulls and no-ops into the unit.
// An item-level predictor of the parser and ring queue sits next to it.
// Every result item is checked field by field, in order, against that
// predictor. Both channels stall at random, with one long receiver hold-off
// and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import scpq_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;
  localparam int DRAIN_CYCLES = 8;

  // Parser position, one step per frame byte
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_LETTER = 3'd1,
    PH_DIGIT0 = 3'd2,
    PH_DIGIT1 = 3'd3,
    PH_TERM   = 3'd4
  } parse_phase_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  scpq_in_if  in_ch ();
  scpq_out_if out_ch ();

  serial_command_parser_with_queue_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // --------------------------------------------------------------------------
  // Predictor state: parser registers and the ring queue
  // --------------------------------------------------------------------------
  parse_phase_e pr_phase;
  logic [7:0]   pr_letter;
  logic [15:0]  pr_digits;
  logic [31:0]  msg_store [QUEUE_DEPTH];
  int           wr_slot;
  int           rd_slot;
  int           held;

  res_t expected_results [$];

  int errors      = 0;
  int items_sent  = 0;
  int results_got = 0;
  int pushes_seen = 0;
  int drops_seen  = 0;
  int pulls_seen  = 0;
  int cycle_count = 0;

  // Idling controls shared between the test tasks and the channel processes
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold    = 0;

  function automatic logic digit_char(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic letter_char(input logic [7:0] c);
    return (c == CH_F) || (c == CH_B) || (c == CH_T) || (c == CH_LT) || (c == CH_S);
  endfunction

  // Append one message; refuse it when the ring is full
  function automatic logic store_message(input logic [31:0] w);
    if (held >= QUEUE_DEPTH) return 1'b0;
    msg_store[wr_slot] = w;
    held++;
    wr_slot = (wr_slot == QUEUE_DEPTH - 1) ? 0 : wr_slot + 1;
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted item and return its result item
  function automatic res_t parse_and_queue(input cmd_e cmd, input logic [7:0] b,
                                           input logic [31:0] w);
    res_t       r;
    logic       done;
    logic [31:0] word;
    r    = '0;
    done = 1'b0;
    word = '0;
    unique case (cmd)
      CMD_BYTE: begin
        unique case (pr_phase)
          PH_LETTER: begin
            if (letter_char(b)) begin
              pr_letter = b;
              pr_phase  = PH_DIGIT0;
            end else begin
              // a second newline lands here too: consume it, no restart
              pr_phase = PH_IDLE;
            end
          end
          PH_DIGIT0: begin
            if (digit_char(b)) begin
              pr_digits[7:0] = b;
              pr_phase       = PH_DIGIT1;
            end else begin
              pr_phase = PH_IDLE;
            end
          end
          PH_DIGIT1: begin
            if (digit_char(b)) begin
              pr_digits[15:8] = b;
              pr_phase        = PH_TERM;
            end else begin
              pr_phase = PH_IDLE;
            end
          end
          PH_TERM: begin
            if ((pr_letter == CH_S) ? digit_char(b) : (b == CH_BANG)) begin
              word = {b, pr_digits, pr_letter};
              done = 1'b1;
            end
            pr_phase = PH_IDLE;
          end
          default: begin
            pr_phase = (b == CH_NL) ? PH_LETTER : PH_IDLE;
          end
        endcase
        if (done) begin
          if (store_message(word)) r.pushed = 1'b1;
          else r.dropped = 1'b1;
        end
      end
      CMD_PUSH: begin
        if (store_message(w)) r.pushed = 1'b1;
        else r.dropped = 1'b1;
      end
      CMD_PULL: begin
        if (held > 0) begin
          r.pull_valid  = 1'b1;
          r.pulled_word = msg_store[rd_slot];
          held--;
          rd_slot = (rd_slot == QUEUE_DEPTH - 1) ? 0 : rd_slot + 1;
        end
      end
      default: ;
    endcase
    r.queue_count = held[QCNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < PRINT_LIMIT)
      $display("%0t mismatch on %s: got %0h, want %0h (result %0d)",
               $realtime, what, got, want, results_got);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset and timeout
  // --------------------------------------------------------------------------
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               expected_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each input handshake, check on each result handshake.
  // One process does both so no ordering inside a time step matters.
  // --------------------------------------------------------------------------
  res_t want_res;
  res_t pred_res;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result item", out_ch.pulled_word, '0);
        end else begin
          want_res = expected_results.pop_front();
          if (out_ch.pushed !== want_res.pushed)
            report_mismatch("pushed", 32'(out_ch.pushed), 32'(want_res.pushed));
          if (out_ch.dropped !== want_res.dropped)
            report_mismatch("dropped", 32'(out_ch.dropped), 32'(want_res.dropped));
          if (out_ch.pull_valid !== want_res.pull_valid)
            report_mismatch("pull_valid", 32'(out_ch.pull_valid),
                            32'(want_res.pull_valid));
          if (out_ch.pulled_word !== want_res.pulled_word)
            report_mismatch("pulled_word", out_ch.pulled_word, want_res.pulled_word);
          if (out_ch.queue_count !== want_res.queue_count)
            report_mismatch("queue_count", 32'(out_ch.queue_count),
                            32'(want_res.queue_count));
          if (want_res.pushed) pushes_seen++;
          if (want_res.dropped) drops_seen++;
          if (want_res.pull_valid) pulls_seen++;
        end
        results_got++;
      end
      if (in_ch.valid && in_ch.ready) begin
        pred_res = parse_and_queue(cmd_e'(in_ch.command), in_ch.rx_byte,
                                   in_ch.push_word);
        expected_results.push_back(pred_res);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    burst        = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_ch.ready = 1'b0;
        rx_hold--;
      end else if (!rx_idle_en) begin
        out_ch.ready = 1'b1;
      end else if (burst > 0) begin
        out_ch.ready = 1'b0;
        burst--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        burst        = $urandom_range(1, 9) - 1;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // Offer one item and hold it until the unit takes it. Valid stays high on
  // return so back-to-back items need no gap.
  task automatic send_item(input cmd_e cmd, input logic [7:0] b, input logic [31:0] w);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_ch.valid     = 1'b1;
    in_ch.command   = cmd;
    in_ch.rx_byte   = b;
    in_ch.push_word = w;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_BYTE, b, $urandom());
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_results_done();
    @(negedge clk_i);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_letter();
    unique case ($urandom_range(0, 4))
      0:       return CH_F;
      1:       return CH_B;
      2:       return CH_T;
      3:       return CH_LT;
      default: return CH_S;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Send one frame; when broken, corrupt one of the four bytes after newline
  task automatic send_frame(input bit broken);
    logic [7:0] fb [4];
    int         spot;
    fb[0] = pick_letter();
    fb[1] = pick_digit();
    fb[2] = pick_digit();
    fb[3] = (fb[0] == CH_S) ? pick_digit() : CH_BANG;
    if (broken) begin
      spot = $urandom_range(0, 3);
      fb[spot] = ($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom_range(0, 255));
    end
    send_byte(CH_NL);
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty pull, no-op, good frames of both kinds, and the ways a frame fails
  task automatic test_frames_directed();
    send_item(CMD_PULL, 8'h00, 32'h0);
    send_item(CMD_NONE, 8'hFF, 32'hFFFF_FFFF);
    send_string("\nF09!");
    send_string("\ns990");
    // newline in the letter slot is consumed, the T after it is ignored
    send_string("\n\nT");
    // unexpected byte in the digit slot
    send_string("\nt1x");
    // wrong terminator for a non-s letter
    send_string("\nB12s");
    wait_results_done();
  endtask

  // Fill the ring with direct pushes, overflow it, then empty it past zero
  task automatic test_queue_limits();
    send_item(CMD_PUSH, 8'h00, 32'h0000_0000);
    send_item(CMD_PUSH, 8'hFF, 32'hFFFF_FFFF);
    while (held < QUEUE_DEPTH) send_item(CMD_PUSH, 8'h00, $urandom());
    send_item(CMD_PUSH, 8'h00, $urandom());
    repeat (QUEUE_DEPTH + 1) send_item(CMD_PULL, 8'h00, 32'h0);
    wait_results_done();
  endtask

  // One random item drawn from a fill-biased or a drain-biased mix
  task automatic send_random_mix(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 45) send_frame(1'b0);
      else if (r < 55) send_frame(1'b1);
      else if (r < 65) send_byte(8'($urandom_range(0, 255)));
      else if (r < 80) send_item(CMD_PUSH, 8'($urandom()), $urandom());
      else if (r < 95) send_item(CMD_PULL, 8'($urandom()), $urandom());
      else send_item(CMD_NONE, 8'($urandom()), $urandom());
    end else begin
      if (r < 20) send_frame(1'b0);
      else if (r < 25) send_frame(1'b1);
      else if (r < 35) send_byte(8'($urandom_range(0, 255)));
      else if (r < 40) send_item(CMD_PUSH, 8'($urandom()), $urandom());
      else if (r < 95) send_item(CMD_PULL, 8'($urandom()), $urandom());
      else send_item(CMD_NONE, 8'($urandom()), $urandom());
    end
  endtask

  // Random items from the fill-biased and drain-biased mixes, swinging the queue level
  task automatic test_random_traffic(input int n_items);
    int  start;
    bit  filling;
    int  epoch;
    start   = items_sent;
    filling = 1'b1;
    epoch   = 0;
    while (items_sent - start < n_items) begin
      send_random_mix(filling);
      epoch++;
      if (epoch >= $urandom_range(20, 60)) begin
        filling = ~filling;
        epoch   = 0;
      end
    end
    wait_results_done();
  endtask

  // Hold the receiver off long enough that the output stage fills and the
  // input stalls, keep offering items, then pause until all results are back
  task automatic test_backpressure();
    rx_hold = 60;
    repeat (6) send_frame(1'b0);
    repeat (8) send_item(CMD_PULL, 8'h00, 32'h0);
    wait_results_done();
    repeat (4) send_item(CMD_PUSH, 8'h00, $urandom());
    wait_results_done();
    repeat (4) send_item(CMD_PULL, 8'h00, 32'h0);
    wait_results_done();
  endtask

  // Full rate on both sides to close the run
  task automatic test_streaming(input int n_items);
    int start;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    start      = items_sent;
    while (items_sent - start < n_items) send_random_mix($urandom_range(0, 1));
    wait_results_done();
  endtask

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_NONE;
    in_ch.rx_byte   = '0;
    in_ch.push_word = '0;
    @(posedge rst_ni);
    // predictor comes out of reset with the unit
    pr_phase  = PH_IDLE;
    pr_letter = '0;
    pr_digits = '0;
    wr_slot   = 0;
    rd_slot   = 0;
    held      = 0;
    foreach (msg_store[i]) msg_store[i] = '0;

    test_frames_directed();
    test_queue_limits();
    test_backpressure();
    test_random_traffic(900);
    test_streaming(200);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);

    $display("run covered %0d items and %0d results: %0d stored, %0d lost to a full queue",
             items_sent, results_got, pushes_seen, drops_seen);
    $display("%0d messages pulled, with random stalls, a long receiver hold-off and %0s",
             pulls_seen, "a full-rate tail");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/scpq_pkg.sv
sv/scpq_if.sv
sv/serial_command_parser_with_queue_unit.sv
bench/testbench.sv
